/* hw/rtl/cle_pkg.sv */
`timescale 1ns / 1ps

package cle_pkg;

  localparam int MAX_LINE_DEF = 64;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TLD = 8'h7E;
  localparam logic [7:0] CH_DEL = 8'h7F;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  // what a request produces on the result side
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CHAR,
    ACT_CRLF,
    ACT_ERASE,
    ACT_TAKE_NONE,
    ACT_TAKE_EMPTY,
    ACT_TAKE_LINE
  } act_t;

  typedef struct packed {
    logic apply;
    logic step_clr;
    logic step_inc;
    logic rd_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    act_t act;
    logic slot_free;
    logic step_last;
  } dp_status_t;

endpackage

/* hw/rtl/cle_ctrl.sv */
`timescale 1ns / 1ps

module cle_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cle_pkg::dp_status_t   status,
  output cle_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_RD,
    S_LINE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.apply    = 1'b1;
          cmd.step_clr = 1'b1;
          case (status.act)
            cle_pkg::ACT_NONE:      state_next = S_IDLE;
            cle_pkg::ACT_TAKE_LINE: state_next = S_RD;
            default:                state_next = S_EMIT;
          endcase
        end
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.out_load = 1'b1;
          if (status.step_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step_inc = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LINE;
      end
      S_LINE: begin
        if (status.slot_free) begin
          cmd.out_load = 1'b1;
          if (status.step_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step_inc = 1'b1;
            state_next   = S_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/cle_datapath.sv */
`timescale 1ns / 1ps

module cle_datapath #(
  parameter int MAX_LINE = cle_pkg::MAX_LINE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_command,
  input  logic [7:0]            in_rx_data,
  input  logic                  cfg_we,
  input  logic                  cfg_echo_on,
  input  cle_pkg::ctrl_cmd_t    cmd,
  output cle_pkg::dp_status_t   status,
  input  logic                  res_ready,
  output logic                  res_valid,
  output logic [1:0]            res_kind,
  output logic [7:0]            res_byte,
  output logic                  res_last,
  output logic                  res_waiting
);

  localparam int LEN_W  = $clog2(MAX_LINE);
  localparam int STEP_W = (LEN_W < 2) ? 2 : LEN_W;
  localparam int ADDR_W = LEN_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE - 1);

  // two banks: one takes edits, the other holds the pending line
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data;

  logic              echo_on;
  logic [LEN_W-1:0]  edit_len;
  logic [LEN_W-1:0]  held_len;
  logic              held_valid;
  logic              edit_bank;
  logic              held_bank;

  cle_pkg::act_t     act;
  cle_pkg::act_t     act_q;
  logic [7:0]        byte_q;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] last_idx;

  logic is_eol;
  logic is_erase;
  logic is_print;
  logic has_room;

  logic [1:0] kind_sel;
  logic [7:0] byte_sel;

  always_comb begin
    is_eol   = (in_rx_data == cle_pkg::CH_CR) || (in_rx_data == cle_pkg::CH_LF);
    is_erase = (in_rx_data == cle_pkg::CH_BS) || (in_rx_data == cle_pkg::CH_DEL);
    is_print = (in_rx_data >= cle_pkg::CH_SP) && (in_rx_data <= cle_pkg::CH_TLD);
    has_room = edit_len < LEN_LIMIT;
    act      = cle_pkg::ACT_NONE;
    if (in_command == cle_pkg::CMD_TAKE) begin
      if (!held_valid) begin
        act = cle_pkg::ACT_TAKE_NONE;
      end else if (held_len == '0) begin
        act = cle_pkg::ACT_TAKE_EMPTY;
      end else begin
        act = cle_pkg::ACT_TAKE_LINE;
      end
    end else if (is_eol) begin
      if (echo_on) act = cle_pkg::ACT_CRLF;
    end else if (is_erase) begin
      if (echo_on && (edit_len != '0)) act = cle_pkg::ACT_ERASE;
    end else if (is_print) begin
      if (echo_on && has_room) act = cle_pkg::ACT_CHAR;
    end
  end

  always_comb begin
    case (act_q)
      cle_pkg::ACT_CRLF:      last_idx = STEP_W'(1);
      cle_pkg::ACT_ERASE:     last_idx = STEP_W'(2);
      cle_pkg::ACT_TAKE_LINE: last_idx = STEP_W'(held_len - LEN_W'(1));
      default:                last_idx = '0;
    endcase
  end

  always_comb begin
    kind_sel = cle_pkg::KIND_ECHO;
    byte_sel = 8'd0;
    case (act_q)
      cle_pkg::ACT_CHAR:       byte_sel = byte_q;
      cle_pkg::ACT_CRLF:       byte_sel = (step == '0) ? cle_pkg::CH_CR : cle_pkg::CH_LF;
      cle_pkg::ACT_ERASE:      byte_sel = (step == STEP_W'(1)) ? cle_pkg::CH_SP
                                                               : cle_pkg::CH_BS;
      cle_pkg::ACT_TAKE_NONE:  kind_sel = cle_pkg::KIND_NONE;
      cle_pkg::ACT_TAKE_EMPTY: kind_sel = cle_pkg::KIND_EMPTY;
      cle_pkg::ACT_TAKE_LINE: begin
        kind_sel = cle_pkg::KIND_LINE;
        byte_sel = rd_data;
      end
      default: byte_sel = 8'd0;
    endcase
  end

  assign status.act       = act;
  assign status.slot_free = !res_valid || res_ready;
  assign status.step_last = (step == last_idx);

  // line state, applied when the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_on    <= 1'b1;
      edit_len   <= '0;
      held_len   <= '0;
      held_valid <= 1'b0;
      edit_bank  <= 1'b0;
      held_bank  <= 1'b1;
      act_q      <= cle_pkg::ACT_NONE;
    end else begin
      if (cfg_we) echo_on <= cfg_echo_on;
      if (cmd.apply) begin
        act_q <= act;
        if (in_command == cle_pkg::CMD_TAKE) begin
          held_valid <= 1'b0;
        end else if (is_eol) begin
          if (!held_valid) begin
            held_bank  <= edit_bank;
            edit_bank  <= held_bank;
            held_len   <= edit_len;
            held_valid <= 1'b1;
          end
          edit_len <= '0;
        end else if (is_erase) begin
          if (edit_len != '0) edit_len <= edit_len - LEN_W'(1);
        end else if (is_print && has_room) begin
          edit_len <= edit_len + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) byte_q <= in_rx_data;
    if (cmd.step_clr) begin
      step <= '0;
    end else if (cmd.step_inc) begin
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && (in_command == cle_pkg::CMD_BYTE) && is_print && has_room) begin
      mem[{edit_bank, edit_len}] <= in_rx_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[{held_bank, step[LEN_W-1:0]}];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_kind    <= kind_sel;
      res_byte    <= byte_sel;
      res_last    <= status.step_last;
      res_waiting <= held_valid;
    end
  end

endmodule

/* hw/rtl/console_line_editor_core.sv */
`timescale 1ns / 1ps

// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_ready  | command, rx_data
// cfg      | cfg_valid/cfg_ready  | echo_on
// out      | out_valid/out_ready  | result_kind, out_byte, last, line_waiting
//
// A byte request is taken in S_IDLE; its echo bytes (up to 3) then go out one per cycle
// while out_ready does not stall. A take request walks the held line through S_RD and
// S_LINE for each byte, since the line buffer memory has a registered read port.
// Reset clears line lengths, the pending flag and sets echo on; buffers are not cleared.
// A stalled out_ready holds the result register and the sequencer waits behind it.

module console_line_editor_core #(
  parameter int MAX_LINE = cle_pkg::MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] rx_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       echo_on,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] result_kind,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       line_waiting
);

  cle_pkg::ctrl_cmd_t  cmd;
  cle_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cle_datapath #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_command  (command),
    .in_rx_data  (rx_data),
    .cfg_we      (cfg_valid),
    .cfg_echo_on (echo_on),
    .cmd         (cmd),
    .status      (status),
    .res_ready   (out_ready),
    .res_valid   (out_valid),
    .res_kind    (result_kind),
    .res_byte    (out_byte),
    .res_last    (last),
    .res_waiting (line_waiting)
  );

endmodule

/* hw/rtl/cle_checker.sv */
`timescale 1ns / 1ps

module cle_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] result_kind,
  input logic [7:0] out_byte,
  input logic       last,
  input logic       line_waiting
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(result_kind)
                                && $stable(last))
    else $error("result changed while stalled");

  a_take_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == cle_pkg::KIND_NONE || result_kind == cle_pkg::KIND_EMPTY)
    |-> last && (out_byte == 8'd0) && !line_waiting)
    else $error("take status result malformed");

  a_line_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == cle_pkg::KIND_LINE) |-> !line_waiting)
    else $error("line byte with slot still full");

  a_line_print: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == cle_pkg::KIND_LINE)
    |-> (out_byte >= cle_pkg::CH_SP) && (out_byte <= cle_pkg::CH_TLD))
    else $error("line byte not printable");

endmodule

bind console_line_editor_core cle_checker u_chk (.*);

/* bench/console_line_editor_core_test.sv */
`timescale 1ns / 1ps

module console_line_editor_core_test;

  localparam int LINE_CAP = cle_pkg::MAX_LINE_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQUESTS = 36;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       waiting;
  } outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = cle_pkg::CMD_BYTE;
  logic [7:0] rx_data = 8'h00;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       echo_on = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic       last;
  logic       line_waiting;

  // editor state as predicted
  logic       echo_model = 1'b1;
  logic [7:0] edit_buf [LINE_CAP];
  logic [7:0] held_buf [LINE_CAP];
  int         edit_len = 0;
  int         held_len = 0;
  logic       held_valid = 1'b0;

  request_t   pending_requests [$];
  outcome_t   due_output [$];

  int cycle_count = 0;
  int requests_offered = 0;
  int requests_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_requests = 0;
  int tx_max_gap = 0;
  int rx_max_gap = 0;
  int takes_sent = 0;
  int lines_lost = 0;
  int full_drops = 0;

  console_line_editor_core #(
    .MAX_LINE(LINE_CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .rx_data(rx_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .echo_on(echo_on),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .out_byte(out_byte),
    .last(last),
    .line_waiting(line_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic outcome_t shaped(input logic [1:0] k, input logic [7:0] b);
    outcome_t o;
    o = '0;
    o.kind = k;
    o.data = b;
    return o;
  endfunction

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  task automatic advance_editor(input request_t r);
    outcome_t burst [$];
    outcome_t o;
    int i;
    if (r.cmd == cle_pkg::CMD_TAKE) begin
      if (!held_valid) begin
        burst.push_back(shaped(cle_pkg::KIND_NONE, 8'h00));
      end else if (held_len == 0) begin
        held_valid = 1'b0;
        burst.push_back(shaped(cle_pkg::KIND_EMPTY, 8'h00));
      end else begin
        for (i = 0; i < held_len && i < LINE_CAP - 1; i++)
          burst.push_back(shaped(cle_pkg::KIND_LINE, held_buf[i]));
        held_valid = 1'b0;
      end
    end else if (r.data == cle_pkg::CH_CR || r.data == cle_pkg::CH_LF) begin
      if (echo_model) begin
        burst.push_back(shaped(cle_pkg::KIND_ECHO, cle_pkg::CH_CR));
        burst.push_back(shaped(cle_pkg::KIND_ECHO, cle_pkg::CH_LF));
      end
      if (!held_valid) begin
        held_buf = edit_buf;
        held_len = edit_len;
        held_valid = 1'b1;
      end else begin
        lines_lost++;
      end
      edit_len = 0;
    end else if (r.data == cle_pkg::CH_BS || r.data == cle_pkg::CH_DEL) begin
      if (edit_len > 0) begin
        edit_len--;
        if (echo_model) begin
          burst.push_back(shaped(cle_pkg::KIND_ECHO, cle_pkg::CH_BS));
          burst.push_back(shaped(cle_pkg::KIND_ECHO, cle_pkg::CH_SP));
          burst.push_back(shaped(cle_pkg::KIND_ECHO, cle_pkg::CH_BS));
        end
      end
    end else if (r.data >= cle_pkg::CH_SP && r.data <= cle_pkg::CH_TLD) begin
      if (edit_len < LINE_CAP - 1) begin
        edit_buf[edit_len] = r.data;
        edit_len++;
        if (echo_model) burst.push_back(shaped(cle_pkg::KIND_ECHO, r.data));
      end else begin
        full_drops++;
      end
    end
    for (i = 0; i < burst.size(); i++) begin
      o = burst[i];
      o.waiting = held_valid;
      o.last = (i == burst.size() - 1);
      due_output.push_back(o);
    end
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("console_line_editor_core_test failed");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_output.size() == 0) begin
          report("result with nothing due, kind", result_kind, 0);
        end else begin
          want = due_output.pop_front();
          if (result_kind !== want.kind) report("result_kind", result_kind, want.kind);
          if (out_byte !== want.data) report("out_byte", out_byte, want.data);
          if (last !== want.last) report("last", last, want.last);
          if (line_waiting !== want.waiting) report("line_waiting", line_waiting, want.waiting);
        end
      end
      if (in_valid && in_ready) begin
        requests_taken++;
        advance_editor({command, rx_data});
      end
    end
  end

  // sender
  always @(negedge clk) begin : feed
    request_t r;
    int tx_gap;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else if (!in_valid || requests_taken == requests_offered) begin
      if (in_valid) tx_gap = $urandom_range(tx_max_gap, 0);
      if (tx_gap == 0 && pending_requests.size() > 0) begin
        r = pending_requests.pop_front();
        in_valid <= 1'b1;
        command <= r.cmd;
        rx_data <= r.data;
        requests_offered++;
      end else begin
        in_valid <= 1'b0;
        if (tx_gap > 0) tx_gap--;
      end
    end
  end

  // receiver, with its own long hold count
  always @(negedge clk) begin : drain
    int rx_gap;
    int hold_left;
    int holds_started;
    int results_counted;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
      holds_started = 0;
      results_counted = 0;
    end else begin
      if (holds_started != hold_requests) begin
        holds_started = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (results_counted != results_seen) begin
        results_counted = results_seen;
        rx_gap = $urandom_range(rx_max_gap, 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_request(input logic c, input logic [7:0] d);
    request_t r;
    r.cmd = c;
    r.data = d;
    pending_requests.push_back(r);
    if (c == cle_pkg::CMD_TAKE) takes_sent++;
  endtask

  task automatic add_printable();
    add_request(cle_pkg::CMD_BYTE, 8'($urandom_range(cle_pkg::CH_TLD, cle_pkg::CH_SP)));
  endtask

  // mostly whole lines with random content, else a single noise byte or take
  task automatic add_session(inout int added);
    int len;
    int i;
    int roll;
    logic long_line;
    roll = $urandom_range(99, 0);
    if (roll < 70) begin
      long_line = ($urandom_range(19, 0) == 0);
      len = long_line ? $urandom_range(70, 60) : $urandom_range(12, 0);
      for (i = 0; i < len; i++) begin
        if (!long_line && $urandom_range(7, 0) == 0)
          add_request(cle_pkg::CMD_BYTE, $urandom_range(1, 0) ? cle_pkg::CH_BS : cle_pkg::CH_DEL);
        else
          add_printable();
      end
      add_request(cle_pkg::CMD_BYTE, $urandom_range(1, 0) ? cle_pkg::CH_CR : cle_pkg::CH_LF);
      added += len + 1;
      if ($urandom_range(3, 0) != 0) begin
        add_request(cle_pkg::CMD_TAKE, 8'($urandom_range(255, 0)));
        added++;
      end
    end else if (roll < 85) begin
      add_request(cle_pkg::CMD_BYTE, 8'($urandom_range(255, 0)));
      added++;
    end else begin
      add_request(cle_pkg::CMD_TAKE, 8'($urandom_range(255, 0)));
      added++;
    end
  endtask

  task automatic write_echo(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    echo_on <= v;
    do @(posedge clk); while (!cfg_ready);
    echo_model = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_requests.size() != 0 || requests_taken != requests_offered ||
           due_output.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int tx_modes [RANDOM_PHASES];
    int rx_modes [RANDOM_PHASES];
    logic echo_modes [RANDOM_PHASES];
    int p;
    int added;
    tx_modes = '{11, 0, 0, 11, 11, 0};
    rx_modes = '{11, 0, 11, 0, 11, 0};
    echo_modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_echo(1'b1);
    tx_max_gap = 11;
    rx_max_gap = 11;
    add_request(cle_pkg::CMD_TAKE, 8'h00);
    add_request(cle_pkg::CMD_BYTE, cle_pkg::CH_CR);
    add_request(cle_pkg::CMD_TAKE, 8'h00);
    add_request(cle_pkg::CMD_BYTE, cle_pkg::CH_BS);
    add_request(cle_pkg::CMD_BYTE, cle_pkg::CH_SP);
    add_request(cle_pkg::CMD_BYTE, cle_pkg::CH_TLD);
    add_request(cle_pkg::CMD_BYTE, cle_pkg::CH_DEL);
    add_request(cle_pkg::CMD_BYTE, 8'h41);
    add_request(cle_pkg::CMD_BYTE, 8'h00);
    add_request(cle_pkg::CMD_BYTE, 8'hFF);
    add_request(cle_pkg::CMD_BYTE, 8'h1F);
    add_request(cle_pkg::CMD_BYTE, 8'h80);
    add_request(cle_pkg::CMD_BYTE, cle_pkg::CH_BS);
    add_request(cle_pkg::CMD_BYTE, cle_pkg::CH_LF);
    add_request(cle_pkg::CMD_BYTE, 8'h78);
    add_request(cle_pkg::CMD_BYTE, cle_pkg::CH_CR);
    add_request(cle_pkg::CMD_TAKE, 8'hFF);
    add_request(cle_pkg::CMD_TAKE, 8'h00);
    settle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_echo(echo_modes[p]);
      tx_max_gap = tx_modes[p];
      rx_max_gap = rx_modes[p];
      if (p == 2) hold_requests++;
      added = 0;
      while (added < PHASE_REQUESTS) add_session(added);
      settle();
    end

    $display("%0d requests (%0d takes) and %0d results checked, echo on and off",
             requests_taken, takes_sent, results_seen);
    $display("%0d lines lost behind a pending line, %0d bytes dropped on a full line",
             lines_lost, full_drops);
    if (mismatches == 0) begin
      $display("console_line_editor_core_test passed");
    end else begin
      $display("console_line_editor_core_test failed");
    end
    $finish;
  end

endmodule
